### sv/dat_pkg.sv
// dat_pkg: shared constants and types for the directed adjacency table
// field widths, command and status codes, default sizes
// no dependencies
package dat_pkg;

    localparam int SRC_W   = 6;
    localparam int TGT_W   = 6;
    localparam int TIME_W  = 16;
    localparam int PRICE_W = 16;
    localparam int IDX_W   = 4;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int DEG_W   = 5;

    localparam int SRC_SPAN = 1 << SRC_W;

    localparam int VERTICES_DEF   = 64;
    localparam int MAX_DEGREE_DEF = 16;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_APPL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_OUT_RANGE = 2'd3;

    typedef struct packed {
        logic [TGT_W-1:0]   target;
        logic [TIME_W-1:0]  duration;
        logic [PRICE_W-1:0] price;
    } edge_t;

endpackage

### sv/directed_adjacency_table_unit.sv
// Directed adjacency table: one ordered edge list per source vertex, depends on dat_pkg
// accept to result: read S_CNT, S_READ, S_RESP; no-op or read past end S_CNT, S_RESP; bad source S_RESP
// insert or remove: S_CNT, S_SCAN to a match or the end, S_SHIFT after a remove hit, S_RESP
// scan and shift move one slot a cycle through the edge memory port
// next word accepted the cycle after its result is loaded; a result may wait in the output reg
// reset: control and per-vertex count valid bits clear; edge memory not cleared
module directed_adjacency_table_unit #(
    parameter int VERTICES   = dat_pkg::VERTICES_DEF,
    parameter int MAX_DEGREE = dat_pkg::MAX_DEGREE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd, source_vertex, target_vertex, in_flight_time, in_price, entry_index
    input  logic [dat_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, entry_valid, out_target, out_flight_time, out_price, out_degree
    output logic [dat_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dat_pkg::*;

    localparam int CNT_DEPTH = (VERTICES < SRC_SPAN) ? VERTICES : SRC_SPAN;
    localparam int VW        = $clog2(CNT_DEPTH);
    localparam int SLOTS     = CNT_DEPTH * MAX_DEGREE;
    localparam int AW        = $clog2(SLOTS);
    localparam int CW        = $clog2(MAX_DEGREE + 1);
    localparam int CMPW      = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CNT, S_SCAN, S_READ, S_SHIFT, S_RESP
    } state_t;

    // input word fields
    logic [CMD_W-1:0]   in_cmd;
    logic [SRC_W-1:0]   in_src;
    logic [TGT_W-1:0]   in_tgt;
    logic [TIME_W-1:0]  in_time;
    logic [PRICE_W-1:0] in_price;
    logic [IDX_W-1:0]   in_idx;

    assign in_cmd   = s_tdata[1:0];
    assign in_src   = s_tdata[7:2];
    assign in_tgt   = s_tdata[13:8];
    assign in_time  = s_tdata[29:14];
    assign in_price = s_tdata[45:30];
    assign in_idx   = s_tdata[49:46];

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [VW-1:0]       src_reg, src_next;
    logic [TGT_W-1:0]    tgt_reg, tgt_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic [CW-1:0]       pend_idx_reg, pend_idx_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic                res_valid_reg, res_valid_next;
    edge_t               res_edge_reg, res_edge_next;
    logic [CW-1:0]       res_deg_reg, res_deg_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // edge memory
    edge_t               edge_mem [SLOTS];
    edge_t               mem_rdata_reg;
    logic [AW-1:0]       mem_raddr;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    edge_t               mem_wdata;

    // per-vertex count memory with valid bits
    logic [CW-1:0]        cnt_mem [CNT_DEPTH];
    logic [CNT_DEPTH-1:0] cnt_vld_reg;
    logic [CW-1:0]        cnt_q_reg;
    logic                 cnt_vld_q_reg;
    logic                 cnt_we;
    logic [CW-1:0]        cnt_wdata;

    logic                 src_ok;
    logic                 match;
    logic [CW-1:0]        slot_idx;

    function automatic logic [AW-1:0] slot_addr(input logic [VW-1:0] v,
                                                input logic [CW-1:0] k);
        slot_addr = AW'(v) * AW'(MAX_DEGREE) + AW'(k);
    endfunction

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            edge_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= edge_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg <= '0;
        end else if (cnt_we) begin
            cnt_vld_reg[src_reg] <= 1'b1;
        end
        if (cnt_we) begin
            cnt_mem[src_reg] <= cnt_wdata;
        end
        cnt_q_reg     <= cnt_mem[in_src[VW-1:0]];
        cnt_vld_q_reg <= cnt_vld_reg[in_src[VW-1:0]];
    end

    assign src_ok   = (32'(in_src) < VERTICES);
    assign match    = (mem_rdata_reg.target == tgt_reg);
    assign slot_idx = CW'(idx_reg);

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        src_next        = src_reg;
        tgt_next        = tgt_reg;
        time_next       = time_reg;
        price_next      = price_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        res_edge_next   = res_edge_reg;
        res_deg_next    = res_deg_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        cnt_we          = 1'b0;
        cnt_wdata       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next        = in_cmd;
                    src_next        = in_src[VW-1:0];
                    tgt_next        = in_tgt;
                    time_next       = in_time;
                    price_next      = in_price;
                    idx_next        = in_idx;
                    res_valid_next  = 1'b0;
                    res_edge_next   = '0;
                    res_status_next = ST_DONE;
                    if (src_ok) begin
                        state_next = S_CNT;
                    end else begin
                        res_status_next = ST_OUT_RANGE;
                        res_deg_next    = '0;
                        state_next      = S_RESP;
                    end
                end
            end
            S_CNT: begin
                n_next        = cnt_vld_q_reg ? cnt_q_reg : '0;
                res_deg_next  = n_next;
                issue_next    = '0;
                pend_next     = 1'b0;
                unique case (cmd_reg) inside
                    CMD_INSERT, CMD_REMOVE: begin
                        state_next = S_SCAN;
                    end
                    CMD_READ: begin
                        if (CMPW'(idx_reg) >= CMPW'(n_next)) begin
                            res_status_next = ST_OUT_RANGE;
                            state_next      = S_RESP;
                        end else begin
                            mem_raddr  = slot_addr(src_reg, slot_idx);
                            state_next = S_READ;
                        end
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SCAN: begin
                if (issue_reg < n_reg) begin
                    mem_raddr     = slot_addr(src_reg, issue_reg);
                    issue_next    = issue_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg && match) begin
                    if (cmd_reg == CMD_INSERT) begin
                        res_status_next = ST_NOT_APPL;
                        state_next      = S_RESP;
                    end else begin
                        // shift the tail down over the removed slot
                        issue_next = pend_idx_reg + CW'(1);
                        pend_next  = 1'b0;
                        state_next = S_SHIFT;
                    end
                end else if ((n_reg == '0) ||
                             (pend_reg && (pend_idx_reg == n_reg - CW'(1)))) begin
                    if (cmd_reg == CMD_REMOVE) begin
                        res_status_next = ST_NOT_APPL;
                    end else if (32'(n_reg) >= MAX_DEGREE) begin
                        res_status_next = ST_FULL;
                    end else begin
                        mem_we                = 1'b1;
                        mem_waddr             = slot_addr(src_reg, n_reg);
                        mem_wdata.target      = tgt_reg;
                        mem_wdata.duration    = time_reg;
                        mem_wdata.price       = price_reg;
                        cnt_we                = 1'b1;
                        cnt_wdata             = n_reg + CW'(1);
                        res_deg_next          = n_reg + CW'(1);
                    end
                    state_next = S_RESP;
                end
            end
            S_SHIFT: begin
                if (issue_reg < n_reg) begin
                    mem_raddr     = slot_addr(src_reg, issue_reg);
                    issue_next    = issue_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_addr(src_reg, pend_idx_reg - CW'(1));
                    mem_wdata = mem_rdata_reg;
                end else if (issue_reg >= n_reg) begin
                    cnt_we       = 1'b1;
                    cnt_wdata    = n_reg - CW'(1);
                    res_deg_next = n_reg - CW'(1);
                    state_next   = S_RESP;
                end
            end
            S_READ: begin
                res_valid_next = 1'b1;
                res_edge_next  = mem_rdata_reg;
                state_next     = S_RESP;
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, DEG_W'(res_deg_reg), res_edge_reg.price,
                                     res_edge_reg.duration, res_edge_reg.target,
                                     res_valid_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            pend_reg     <= pend_next;
        end
        cmd_reg        <= cmd_next;
        src_reg        <= src_next;
        tgt_reg        <= tgt_next;
        time_reg       <= time_next;
        price_reg      <= price_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_valid_reg  <= res_valid_next;
        res_edge_reg   <= res_edge_next;
        res_deg_reg    <= res_deg_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
